@@ hdl/assert_macros.svh @@
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant violated");

// consequent must hold whenever the antecedent holds
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

@@ hdl/u8u16_pkg.sv @@
// types and constants for the utf-8 / cesu-8 to utf-16 decoder
// no dependencies
package u8u16_pkg;

	localparam int ACC_W = 26;

	localparam logic [2:0] MAX_SEQ_LEN = 3'd6;

	localparam logic [ACC_W-1:0] OFFSET_2 = ACC_W'(32'h0000_3080);
	localparam logic [ACC_W-1:0] OFFSET_3 = ACC_W'(32'h000E_2080);
	localparam logic [ACC_W-1:0] OFFSET_4 = ACC_W'(32'h03C8_2080);

	localparam logic [ACC_W-1:0] LEAST_2 = ACC_W'(32'h0000_0080);
	localparam logic [ACC_W-1:0] LEAST_3 = ACC_W'(32'h0000_0800);
	localparam logic [ACC_W-1:0] LEAST_4 = ACC_W'(32'h0001_0000);

	localparam logic [ACC_W-1:0] MAX_CODE_POINT = ACC_W'(32'h0010_FFFF);
	localparam logic [ACC_W-1:0] MAX_BMP        = ACC_W'(32'h0000_FFFF);
	localparam logic [ACC_W-1:0] SURR_FIRST     = ACC_W'(32'h0000_D800);
	localparam logic [ACC_W-1:0] SURR_LAST      = ACC_W'(32'h0000_DFFF);
	localparam logic [20:0]      SUPP_BASE      = 21'h1_0000;

	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        status;
		logic [2:0]  bad_length;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} result_pair_t;

endpackage

@@ hdl/utf8_to_utf16_decoder_top.sv @@
// utf-8 / cesu-8 to utf-16 decoder, one byte per item in, one code unit per item out
// an accepted byte is registered, then its results are registered for m_
// throughput: one byte per cycle while the result register is free; a byte's two
//   results (surrogate pair, or error plus a new unit) stay until both are taken
// reset: arst_n clears sequence state, cesu_mode and all valid flags at once
module utf8_to_utf16_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,  // cesu_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // code_unit[15:0], bad_length[18:16], zero fill
	output logic        m_tuser,    // status
	output logic        m_tlast
);
	import u8u16_pkg::*;

	logic         cesu_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         free;
	logic         step;
	result_pair_t results;

	assign s_tready = !valid_s1 || free;
	assign step = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cesu_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we)
				cesu_q <= cfg_wdata;
			if (s_tready)
				valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			byte_s1 <= s_tdata;
	end

	u8u16_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.cesu_mode (cesu_q),
		.results   (results)
	);

	u8u16_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && (results.count != CNT_NONE)),
		.pair     (results),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ hdl/u8u16_core.sv @@
// sequence state and per-byte decode, up to two results per byte
// depends on u8u16_pkg and assert_macros.svh
`include "assert_macros.svh"

module u8u16_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   cesu_mode,
	output u8u16_pkg::result_pair_t results
);
	import u8u16_pkg::*;

	typedef struct packed {
		logic       emit;
		result_t    res;
		logic       open;
		logic [2:0] len;
	} start_t;

	logic             in_seq_q;
	logic [2:0]       exp_len_q;
	logic [2:0]       seen_q;
	logic [ACC_W-1:0] acc_q;

	logic             in_seq_d;
	logic [2:0]       exp_len_d;
	logic [2:0]       seen_d;
	logic [ACC_W-1:0] acc_d;

	start_t           st;
	result_pair_t     fin;
	logic [ACC_W-1:0] acc_sh;
	logic [2:0]       seen_inc;
	logic [2:0]       n_len;
	logic             is_trail;

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b[7:5] == 3'b110) len = 3'd2;
		else if (b[7:4] == 4'b1110) len = 3'd3;
		else if (b[7:3] == 5'b11110) len = 3'd4;
		else if (b[7:2] == 6'b111110) len = 3'd5;
		else if (b[7:1] == 7'b1111110) len = 3'd6;
		return len;
	endfunction

	function automatic start_t start_dec(input logic [7:0] b);
		start_t s;
		logic [2:0] len;
		s = '0;
		len = lead_len(b);
		if (!b[7]) begin
			s.emit = 1'b1;
			s.res.code_unit = {8'd0, b};
		end else if (len == 3'd0) begin
			s.emit = 1'b1;
			s.res.status = 1'b1;
			s.res.bad_length = 3'd1;
		end else begin
			s.open = 1'b1;
			s.len = len;
		end
		return s;
	endfunction

	function automatic result_pair_t finish_dec(input logic [ACC_W-1:0] acc,
			input logic [2:0] n, input logic cesu);
		result_pair_t p;
		logic [ACC_W-1:0] offset;
		logic [ACC_W-1:0] least;
		logic [ACC_W-1:0] cp;
		logic [20:0]      cp2;
		logic             len_ok;
		logic             ok;
		p = '0;
		len_ok = 1'b1;
		case (n)
			3'd2: begin
				offset = OFFSET_2;
				least = LEAST_2;
			end
			3'd3: begin
				offset = OFFSET_3;
				least = LEAST_3;
			end
			3'd4: begin
				offset = OFFSET_4;
				least = LEAST_4;
			end
			3'd0, 3'd1: begin
				offset = '0;
				least = '0;
			end
			default: begin
				offset = '0;
				least = '0;
				len_ok = 1'b0;
			end
		endcase
		cp = acc - offset;
		cp2 = cp[20:0] - SUPP_BASE;
		ok = len_ok && (cp <= MAX_CODE_POINT) && (cp >= least);
		if (cesu)
			ok = ok && (n <= 3'd3);
		else
			ok = ok && !((cp >= SURR_FIRST) && (cp <= SURR_LAST));
		if (!ok) begin
			p.count = CNT_ONE;
			p.r0.status = 1'b1;
			p.r0.bad_length = n;
			p.r0.last = 1'b1;
		end else if (cp <= MAX_BMP) begin
			p.count = CNT_ONE;
			p.r0.code_unit = cp[15:0];
			p.r0.last = 1'b1;
		end else begin
			p.count = CNT_TWO;
			p.r0.code_unit = {HIGH_SURR_TAG, cp2[19:10]};
			p.r1.code_unit = {LOW_SURR_TAG, cp2[9:0]};
			p.r1.last = 1'b1;
		end
		return p;
	endfunction

	always_comb begin
		st = start_dec(data_byte);
		acc_sh = {acc_q[ACC_W-7:0], 6'b0} + ACC_W'(data_byte);
		seen_inc = seen_q + 3'd1;
		n_len = (exp_len_q > MAX_SEQ_LEN) ? MAX_SEQ_LEN : exp_len_q;
		fin = finish_dec(acc_sh, n_len, cesu_mode);
		is_trail = (data_byte[7:6] == 2'b10);

		results = '0;
		in_seq_d = in_seq_q;
		exp_len_d = exp_len_q;
		seen_d = seen_q;
		acc_d = acc_q;

		if (!in_seq_q) begin
			if (st.emit) begin
				results.count = CNT_ONE;
				results.r0 = st.res;
				results.r0.last = 1'b1;
			end
			if (st.open) begin
				in_seq_d = 1'b1;
				exp_len_d = st.len;
				seen_d = 3'd1;
				acc_d = ACC_W'(data_byte);
			end
		end else if (is_trail) begin
			if (seen_inc >= exp_len_q) begin
				results = fin;
				in_seq_d = 1'b0;
				exp_len_d = 3'd0;
				seen_d = 3'd0;
				acc_d = '0;
			end else begin
				seen_d = seen_inc;
				acc_d = acc_sh;
			end
		end else begin
			// interrupted sequence: error first, then restart on this byte
			results.r0.status = 1'b1;
			results.r0.bad_length = seen_q;
			if (st.emit) begin
				results.count = CNT_TWO;
				results.r1 = st.res;
				results.r1.last = 1'b1;
			end else begin
				results.count = CNT_ONE;
				results.r0.last = 1'b1;
			end
			in_seq_d = st.open;
			exp_len_d = st.open ? st.len : 3'd0;
			seen_d = st.open ? 3'd1 : 3'd0;
			acc_d = st.open ? ACC_W'(data_byte) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seq_q <= 1'b0;
			exp_len_q <= 3'd0;
			seen_q <= 3'd0;
			acc_q <= '0;
		end else if (step) begin
			in_seq_q <= in_seq_d;
			exp_len_q <= exp_len_d;
			seen_q <= seen_d;
			acc_q <= acc_d;
		end
	end

	`CHK_IMPLIES(a_seen_below_len, clk, arst_n, in_seq_q, seen_q < exp_len_q)
	`CHK_IMPLIES(a_len_range, clk, arst_n, in_seq_q, (exp_len_q >= 3'd2) && (exp_len_q <= MAX_SEQ_LEN))
	`CHK_IMPLIES(a_idle_clear, clk, arst_n, !in_seq_q, (exp_len_q == 3'd0) && (seen_q == 3'd0))

endmodule

@@ hdl/u8u16_outbuf.sv @@
// result register holding the results of one byte, drained one item a cycle while m_tready is high
// depends on u8u16_pkg and assert_macros.svh
`include "assert_macros.svh"

module u8u16_outbuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  u8u16_pkg::result_pair_t pair,
	output logic                    free,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [23:0]             m_tdata,  // code_unit[15:0], bad_length[18:16], zero fill
	output logic                    m_tuser,  // status
	output logic                    m_tlast
);
	import u8u16_pkg::*;

	logic         valid_q;
	logic         idx_q;
	result_pair_t pair_q;
	result_t      cur;
	logic         last_idx;

	assign last_idx = (pair_q.count == CNT_TWO);
	assign free = !valid_q || (m_tready && (idx_q == last_idx));
	assign cur = idx_q ? pair_q.r1 : pair_q.r0;

	assign m_tvalid = valid_q;
	assign m_tdata = {5'd0, cur.bad_length, cur.code_unit};
	assign m_tuser = cur.status;
	assign m_tlast = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q <= 1'b0;
		end else if (valid_q && m_tready) begin
			if (idx_q == last_idx)
				valid_q <= 1'b0;
			else
				idx_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			pair_q <= pair;
	end

	`CHK_IMPLIES(a_load_when_free, clk, arst_n, load, free && (pair.count != CNT_NONE))
	`CHK_IMPLIES(a_held_nonempty, clk, arst_n, valid_q, pair_q.count != CNT_NONE)
	`CHK_IMPLIES(a_second_needs_pair, clk, arst_n, valid_q && idx_q, pair_q.count == CNT_TWO)

endmodule

@@ dv/tb_utf8_to_utf16_decoder_top.sv @@
`timescale 1ns / 100ps
// testbench for utf8_to_utf16_decoder_top: directed and random byte streams in utf-8 and
// cesu-8 mode, every result item checked against a local decoder model
// depends on u8u16_pkg and the decoder rtl
module tb_utf8_to_utf16_decoder_top;
	import u8u16_pkg::*;

	localparam logic ST_VALID   = 1'b0;
	localparam logic ST_ILLEGAL = 1'b1;
	localparam logic MODE_UTF8  = 1'b0;
	localparam logic MODE_CESU  = 1'b1;

	localparam logic [31:0] CP_MAX        = 32'h0010_FFFF;
	localparam logic [31:0] CP_BMP_MAX    = 32'h0000_FFFF;
	localparam logic [31:0] CP_SUPP_BASE  = 32'h0001_0000;
	localparam logic [31:0] CP_SURR_FIRST = 32'h0000_D800;
	localparam logic [31:0] CP_SURR_LAST  = 32'h0000_DFFF;
	localparam logic [31:0] CP_TEN_BITS   = 32'h0000_03FF;
	localparam logic [15:0] UNIT_HI_SURR  = 16'hD800;
	localparam logic [15:0] UNIT_LO_SURR  = 16'hDC00;
	localparam logic [7:0]  ASCII_LAST    = 8'h7F;
	localparam logic [7:0]  TRAIL_FIRST   = 8'h80;
	localparam logic [7:0]  TRAIL_LAST    = 8'hBF;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 20;
	localparam int PHASE_ITEMS    = 130;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	utf8_to_utf16_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder model state
	logic        mode_cesu = MODE_UTF8;
	logic        seq_open  = 1'b0;
	logic [2:0]  seq_len   = 3'd0;
	logic [2:0]  seq_cnt   = 3'd0;
	logic [31:0] seq_acc   = 32'd0;

	result_t units_q[$];
	result_t pend[2];
	int      npend;

	int  fails        = 0;
	int  bytes_sent   = 0;
	int  units_seen   = 0;
	int  illegal_seen = 0;
	int  idle_cycles  = 0;
	int  stall_left   = 0;
	bit  pace_on      = 1'b1;
	result_t got, want;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		if (b >= 8'hC0 && b <= 8'hDF) return 3'd2;
		if (b >= 8'hE0 && b <= 8'hEF) return 3'd3;
		if (b >= 8'hF0 && b <= 8'hF7) return 3'd4;
		if (b >= 8'hF8 && b <= 8'hFB) return 3'd5;
		if (b >= 8'hFC && b <= 8'hFD) return 3'd6;
		return 3'd0;
	endfunction

	function automatic logic [31:0] len_offset(input logic [2:0] n);
		case (n)
			3'd2: return 32'h0000_3080;
			3'd3: return 32'h000E_2080;
			3'd4: return 32'h03C8_2080;
			3'd5: return 32'hFA08_2080;
			3'd6: return 32'h8208_2080;
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic [31:0] len_least(input logic [2:0] n);
		case (n)
			3'd2: return 32'h0000_0080;
			3'd3: return 32'h0000_0800;
			3'd4: return 32'h0001_0000;
			3'd5, 3'd6: return 32'hFFFF_FFFF;
			default: return 32'h0;
		endcase
	endfunction

	function void emit(input logic [15:0] unit, input logic st, input logic [2:0] bad);
		pend[npend].code_unit  = unit;
		pend[npend].status     = st;
		pend[npend].bad_length = bad;
		pend[npend].last       = 1'b0;
		npend++;
	endfunction

	function void clear_seq();
		seq_open = 1'b0;
		seq_len  = 3'd0;
		seq_cnt  = 3'd0;
		seq_acc  = 32'd0;
	endfunction

	function void start_or_pass(input logic [7:0] b);
		logic [2:0] n;
		n = lead_len(b);
		if (b <= ASCII_LAST)
			emit({8'h00, b}, ST_VALID, 3'd0);
		else if (n == 3'd0)
			emit(16'h0000, ST_ILLEGAL, 3'd1);
		else begin
			seq_open = 1'b1;
			seq_len  = n;
			seq_cnt  = 3'd1;
			seq_acc  = {24'd0, b};
		end
	endfunction

	function void close_seq();
		logic [2:0]  n;
		logic [31:0] cp;
		logic        ok;
		n  = (seq_len > 3'd6) ? 3'd6 : seq_len;
		cp = seq_acc - len_offset(n);
		ok = (cp <= CP_MAX) && (cp >= len_least(n));
		if (mode_cesu == MODE_CESU)
			ok = ok && (n <= 3'd3);
		else
			ok = ok && !(cp >= CP_SURR_FIRST && cp <= CP_SURR_LAST);
		clear_seq();
		if (!ok)
			emit(16'h0000, ST_ILLEGAL, n);
		else if (cp <= CP_BMP_MAX)
			emit(cp[15:0], ST_VALID, 3'd0);
		else begin
			cp = cp - CP_SUPP_BASE;
			emit(16'(cp >> 10) + UNIT_HI_SURR, ST_VALID, 3'd0);
			emit(16'(cp & CP_TEN_BITS) + UNIT_LO_SURR, ST_VALID, 3'd0);
		end
	endfunction

	function void decode_byte(input logic [7:0] b);
		npend = 0;
		if (!seq_open)
			start_or_pass(b);
		else if (b >= TRAIL_FIRST && b <= TRAIL_LAST) begin
			seq_acc = (seq_acc << 6) + {24'd0, b};
			seq_cnt = seq_cnt + 3'd1;
			if (seq_cnt >= seq_len)
				close_seq();
		end else begin
			// interrupted sequence, the byte starts over
			emit(16'h0000, ST_ILLEGAL, seq_cnt);
			clear_seq();
			start_or_pass(b);
		end
		if (npend > 0)
			pend[npend-1].last = 1'b1;
		for (int i = 0; i < npend; i++)
			units_q.push_back(pend[i]);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pace_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		decode_byte(b);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (units_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mode_cesu = m;
	endtask

	task automatic send_three(input logic [15:0] u);
		send_byte(8'hE0 | 8'(u >> 12));
		send_byte(TRAIL_FIRST | 8'((u >> 6) & 16'h3F));
		send_byte(TRAIL_FIRST | 8'(u & 16'h3F));
	endtask

	task automatic send_code_point(input logic [31:0] cp);
		logic [31:0] v;
		if (cp <= 32'h7F)
			send_byte(cp[7:0]);
		else if (cp <= 32'h7FF) begin
			send_byte(8'hC0 | 8'(cp >> 6));
			send_byte(TRAIL_FIRST | 8'(cp & 32'h3F));
		end else if (cp <= CP_BMP_MAX)
			send_three(cp[15:0]);
		else if (mode_cesu == MODE_CESU) begin
			v = cp - CP_SUPP_BASE;
			send_three(16'(v >> 10) + UNIT_HI_SURR);
			send_three(16'(v & CP_TEN_BITS) + UNIT_LO_SURR);
		end else begin
			send_byte(8'hF0 | 8'(cp >> 18));
			send_byte(TRAIL_FIRST | 8'((cp >> 12) & 32'h3F));
			send_byte(TRAIL_FIRST | 8'((cp >> 6) & 32'h3F));
			send_byte(TRAIL_FIRST | 8'(cp & 32'h3F));
		end
	endtask

	// lead byte of the given class, then random trail bytes
	task automatic send_raw_seq(input int len, input int trails);
		logic [7:0] lead;
		case (len)
			2: lead = 8'($urandom_range(8'hC0, 8'hDF));
			3: lead = 8'($urandom_range(8'hE0, 8'hEF));
			4: lead = 8'($urandom_range(8'hF0, 8'hF7));
			5: lead = 8'($urandom_range(8'hF8, 8'hFB));
			default: lead = 8'($urandom_range(8'hFC, 8'hFD));
		endcase
		send_byte(lead);
		repeat (trails) send_byte(8'($urandom_range(TRAIL_FIRST, TRAIL_LAST)));
	endtask

	function automatic logic [31:0] pick_code_point();
		case ($urandom_range(0, 4))
			0: return $urandom_range(32'h80, 32'h7FF);
			1: return $urandom_range(32'h800, CP_BMP_MAX);
			2: return $urandom_range(CP_SURR_FIRST, CP_SURR_LAST);
			3: return $urandom_range(CP_SUPP_BASE, CP_MAX);
			default: begin
				case ($urandom_range(0, 5))
					0: return 32'h80;
					1: return 32'h7FF;
					2: return 32'h800;
					3: return CP_BMP_MAX;
					4: return CP_SUPP_BASE;
					default: return CP_MAX;
				endcase
			end
		endcase
	endfunction

	task automatic send_random_item();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 25)
			send_byte(8'($urandom_range(0, ASCII_LAST)));
		else if (r < 60)
			send_code_point(pick_code_point());
		else if (r < 80) begin
			len = $urandom_range(2, 4);
			send_raw_seq(len, len - 1);
		end else if (r < 85) begin
			len = $urandom_range(5, 6);
			send_raw_seq(len, len - 1);
		end else if (r < 95) begin
			len = $urandom_range(2, 6);
			send_raw_seq(len, $urandom_range(0, len - 2));
		end else
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_single_bytes();
		send_byte(8'h00);
		send_byte(ASCII_LAST);
		send_byte(TRAIL_FIRST);
		send_byte(8'hFE);
		send_byte(8'hFF);
	endtask

	task automatic test_utf8_sequences();
		// overlong two-byte form
		send_byte(8'hC0); send_byte(8'h80);
		// highest code point, surrogate pair out
		send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
		// above the highest code point
		send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
		// surrogate not allowed in utf-8
		send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
		// interrupted by an ascii byte
		send_byte(8'hE2); send_byte(8'h41);
	endtask

	task automatic test_mode_switch_mid_sequence();
		send_byte(8'hE0);
		send_byte(8'hA0);
		set_mode(MODE_CESU);
		send_byte(8'h80);
	endtask

	task automatic test_cesu_sequences();
		send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
		send_byte(8'hF0); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
	endtask

	task automatic test_random_stream();
		int target;
		for (int phase = 0; phase < 4; phase++) begin
			set_mode(phase[0] ? MODE_CESU : MODE_UTF8);
			pace_on = (phase != 2);
			target = bytes_sent + PHASE_ITEMS;
			while (bytes_sent < target) begin
				send_random_item();
				if ($urandom_range(0, 49) == 0)
					wait_idle();
			end
		end
		pace_on = 1'b1;
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (!pace_on)
			m_tready <= 1'b1;
		else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.code_unit  = m_tdata[15:0];
			got.bad_length = m_tdata[18:16];
			got.status     = m_tuser;
			got.last       = m_tlast;
			if (units_q.size() == 0) begin
				$display("%0t: result with nothing expected: unit %h status %b bad_len %0d last %b",
					$time, got.code_unit, got.status, got.bad_length, got.last);
				fails++;
			end else begin
				want = units_q.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch expected unit %h status %b bad_len %0d last %b",
						$time, want.code_unit, want.status, want.bad_length, want.last);
					$display("%0t:          actual   unit %h status %b bad_len %0d last %b",
						$time, got.code_unit, got.status, got.bad_length, got.last);
					fails++;
				end
				if (want.status == ST_ILLEGAL)
					illegal_seen++;
				else
					units_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no item moved for %0d cycles", $time, idle_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_mode(MODE_UTF8);
		test_single_bytes();
		test_utf8_sequences();
		test_mode_switch_mid_sequence();
		test_cesu_sequences();
		test_random_stream();
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d bytes sent in utf-8 and cesu-8 mode with random gaps on both sides",
			bytes_sent);
		$display("%0d code units and %0d illegal results checked, %0d mismatches",
			units_seen, illegal_seen, fails);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
